FILE: rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Types and constants shared by the binary indexed tree point-set/range-sum
// block: item structs, controller states and controller/datapath signals.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned DATA_W = 64;

  localparam logic [POS_W-1:0] USED_SIZE_RST = 11'd1024;

  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         right_end;
    logic signed [DATA_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    logic                     index_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_PV_WR,
    ST_A_RD,
    ST_A_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_SW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic pv_rd;
    logic pv_wr;
    logic ps_rd;
    logic ps_wr;
    logic acc;
    logic to_left;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic err;
    logic act;
    logic chain_end;
    logic walk_end;
    logic left_one;
    logic sub_phase;
  } sts_t;

endpackage

FILE: rtl/fenwick_point_set_range_sum.sv
// ----------------------------------------------------------------------------
// fenwick_point_set_range_sum
// Binary indexed tree over signed 64-bit values with point assign and
// inclusive range sum; sums wrap modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low. Action
//   assign stores new_value at position and gives no result unless the index
//   is out of range. Action query returns the sum from position to right_end.
//   An index outside 1 to used_size gives one result with index_error set
//   and range_sum zero, and the stores are left alone.
//   A result sits on out_item_o for one cycle with res_valid_o high; the
//   receiver cannot stall it, and it arrives while busy is already low.
//   used_size is written through cfg_we_i/cfg_wdata_i by the user, only while
//   the block is idle; the block itself does not enforce this.
// Sequence:
//   Every tree step reads the single-port partial sum memory, then writes or
//   accumulates. An assign walks an upward chain of up to log2(MAX_SIZE)+1
//   steps. A query walks down from right_end, then from position-1, one step
//   per set bit; the left walk is skipped when position is 1.
// Reset:
//   Reset starts a clearing pass that zeroes both memories, addresses 0 to
//   MAX_SIZE; busy stays high until it ends. used_size resets to 1024.
// ----------------------------------------------------------------------------
module fenwick_point_set_range_sum #(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  fps_pkg::in_item_t          in_item_i,
  input  logic                       cfg_we_i,
  input  logic [fps_pkg::POS_W-1:0]  cfg_wdata_i,
  output fps_pkg::out_item_t         out_item_o,
  output logic                       res_valid_o
);
  import fps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fps_dp #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o),
    .res_valid_o (res_valid_o)
  );

endmodule

FILE: rtl/fps_ctrl.sv
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer for the tree: clearing pass, assign chain walk with
// read-modify-write, and the two prefix walks of a range query.
// ----------------------------------------------------------------------------
module fps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fps_pkg::sts_t sts_i,
  output fps_pkg::cmd_t cmd_o
);
  import fps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.err) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else if (sts_i.act == ACT_ASSIGN) begin
          cmd_o.pv_rd = 1'b1;
          state_d     = ST_PV_WR;
        end else begin
          cmd_o.ps_rd = 1'b1;
          state_d     = ST_Q_ACC;
        end
      end
      ST_PV_WR: begin
        cmd_o.pv_wr = 1'b1;
        state_d     = ST_A_RD;
      end
      ST_A_RD: begin
        cmd_o.ps_rd = 1'b1;
        state_d     = ST_A_WR;
      end
      ST_A_WR: begin
        cmd_o.ps_wr = 1'b1;
        state_d     = sts_i.chain_end ? ST_IDLE : ST_A_RD;
      end
      ST_Q_RD: begin
        cmd_o.ps_rd = 1'b1;
        state_d     = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        cmd_o.acc = 1'b1;
        if (!sts_i.walk_end) begin
          state_d = ST_Q_RD;
        end else if (sts_i.sub_phase || sts_i.left_one) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_Q_SW;
        end
      end
      ST_Q_SW: begin
        cmd_o.to_left = 1'b1;
        state_d       = ST_Q_RD;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/fps_dp.sv
// ----------------------------------------------------------------------------
// fps_dp
// Datapath: size register, item registers, plain value and partial sum
// memories, chain index arithmetic, accumulator and result register.
// ----------------------------------------------------------------------------
module fps_dp #(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fps_pkg::cmd_t              cmd_i,
  output fps_pkg::sts_t              sts_o,
  input  fps_pkg::in_item_t          in_item_i,
  input  logic                       cfg_we_i,
  input  logic [fps_pkg::POS_W-1:0]  cfg_wdata_i,
  output fps_pkg::out_item_t         out_item_o,
  output logic                       res_valid_o
);
  import fps_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SIZE + 1);
  localparam int unsigned IW = AW + 1;

  logic [POS_W-1:0]  used_size_q;
  logic [AW-1:0]     clr_q;
  logic              res_valid_q;

  logic              act_q;
  logic              err_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [IW-1:0]     idx_q;
  logic [DATA_W-1:0] delta_q;
  logic [DATA_W-1:0] acc_q;
  logic              sub_q;
  logic [DATA_W-1:0] ps_rdata_q;
  logic [DATA_W-1:0] pv_rdata_q;
  logic [DATA_W-1:0] res_q;
  logic              res_err_q;

  logic [DATA_W-1:0] ps_mem [0:MAX_SIZE];
  logic [DATA_W-1:0] pv_mem [0:MAX_SIZE];

  logic [IW-1:0]     lowbit;
  logic [IW-1:0]     idx_up;
  logic [IW-1:0]     idx_dn;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     wr_addr;
  logic              pos_ok;
  logic              right_ok;

  function automatic logic index_ok(logic [POS_W-1:0] x, logic [POS_W-1:0] size);
    return (x != '0) && (x <= size) && (32'(x) <= 32'(MAX_SIZE));
  endfunction

  assign lowbit  = idx_q & (~idx_q + IW'(1));
  assign idx_up  = idx_q + lowbit;
  assign idx_dn  = idx_q - lowbit;
  assign addr    = idx_q[AW-1:0];
  assign wr_addr = cmd_i.clr ? clr_q : addr;

  assign pos_ok   = index_ok(in_item_i.position, used_size_q);
  assign right_ok = index_ok(in_item_i.right_end, used_size_q);

  always_comb begin
    sts_o.clr_done  = (clr_q == AW'(MAX_SIZE));
    sts_o.err       = err_q;
    sts_o.act       = act_q;
    sts_o.chain_end = (idx_up > IW'(MAX_SIZE));
    sts_o.walk_end  = (idx_dn == '0);
    sts_o.left_one  = (pos_q == POS_W'(1));
    sts_o.sub_phase = sub_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= USED_SIZE_RST;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        used_size_q <= cfg_wdata_i;
      end
      if (cmd_i.clr && !sts_o.clr_done) begin
        clr_q <= clr_q + AW'(1);
      end
      res_valid_q <= cmd_i.emit;
    end
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_item_i.action;
      pos_q <= in_item_i.position;
      val_q <= in_item_i.new_value;
      idx_q <= (in_item_i.action == ACT_QUERY) ? IW'(in_item_i.right_end)
                                               : IW'(in_item_i.position);
      err_q <= !(pos_ok && ((in_item_i.action == ACT_ASSIGN) || right_ok));
      acc_q <= '0;
      sub_q <= 1'b0;
    end
    if (cmd_i.pv_wr) begin
      delta_q <= val_q - pv_rdata_q;
    end
    if (cmd_i.ps_wr) begin
      idx_q <= idx_up;
    end
    if (cmd_i.acc) begin
      acc_q <= (sub_q ? (acc_q - ps_rdata_q) : (acc_q + ps_rdata_q));
      idx_q <= idx_dn;
    end
    if (cmd_i.to_left) begin
      idx_q <= IW'(pos_q) - IW'(1);
      sub_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      res_q     <= err_q ? '0 : acc_q;
      res_err_q <= err_q;
    end
  end

  // partial sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr || cmd_i.ps_wr) begin
      ps_mem[wr_addr] <= cmd_i.clr ? '0 : (ps_rdata_q + delta_q);
    end
    if (cmd_i.ps_rd) begin
      ps_rdata_q <= ps_mem[addr];
    end
  end

  // plain values
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr || cmd_i.pv_wr) begin
      pv_mem[wr_addr] <= cmd_i.clr ? '0 : val_q;
    end
    if (cmd_i.pv_rd) begin
      pv_rdata_q <= pv_mem[addr];
    end
  end

  assign out_item_o.range_sum   = res_q;
  assign out_item_o.index_error = res_err_q;
  assign res_valid_o            = res_valid_q;

endmodule

FILE: rtl/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on the tree block: item handshake, result pulses and
// error results.
// ----------------------------------------------------------------------------
module fps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input fps_pkg::out_item_t out_item_o,
  input logic               res_valid_o
);
  import fps_pkg::*;

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after item accepted");

  // results are single-cycle pulses
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  // the item is finished when its result shows
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result while block busy");

  // an error result carries a zero sum
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_item_o.index_error) |-> (out_item_o.range_sum == '0))
    else $error("error result with nonzero sum");

endmodule

bind fenwick_point_set_range_sum fps_checker u_fps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_item_o  (out_item_o),
  .res_valid_o (res_valid_o)
);
